// ===== rtl/core/wmh64_pkg.sv =====
// Package with the types, constants and helper functions of the word mix hash block.
`default_nettype none
package wmh64_pkg;

    // Mixing and finalizer constants.
    localparam logic [63:0] HASH_K1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_K2 = 64'h6c62272e07bb0142;
    localparam logic [63:0] HASH_K3 = 64'h94d049bb133111eb;
    localparam int unsigned MIX_ROT = 27;
    localparam int unsigned FIN_SH1 = 33;
    localparam int unsigned FIN_SH2 = 29;
    localparam int unsigned FIN_SH3 = 32;

    // Number of byte lanes in one data word.
    localparam int unsigned LANES = 8;

    // Sequencer phases: each working phase runs one 64-bit multiply.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MIX1,
        PH_MIX2,
        PH_FIN1,
        PH_FIN2,
        PH_EMIT
    } phase_t;

    // Steps of one 64x64 low-half multiply on the shared 32x32 multiplier.
    typedef enum logic [1:0] {
        MS_LOLO,
        MS_HILO,
        MS_LOHI,
        MS_SUM
    } mul_step_t;

    // Keep the byte lanes below count; counts of eight and above keep all lanes.
    function automatic logic [63:0] lane_mask(input logic [3:0] count);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < LANES; i++) begin
            if (count > 4'(i)) begin
                mask[i*8 +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/word_mix_hash64.sv =====
// Streaming 64-bit word hash with an avalanche finalizer, built on one shared multiplier.
//
// Requests arrive on the input channel (in_valid / in_stall), one 64-bit word each.
// A request marked first_word seeds the running hash from total_length; each request
// with a nonzero valid_bytes is masked and mixed in. A request marked last_word
// finalizes the hash, and the digest is offered on the output channel
// (out_valid / out_stall) from a result register.
// Every 64-bit multiply runs as three partial products on one 32x32 multiplier
// plus a final sum step. Mixing a word needs two multiplies, and a word that is
// not last holds the input side stalled until both are done. A last word adds
// two finalizer multiplies and a step to load the result register; an empty
// last word runs only the finalizer multiplies and that load step.
// in_stall is high while the sequencer works on a request. The input side is
// free again once the digest sits in the result register, even while the
// receiver stalls; a later digest waits in its load step until the register
// is taken. Reset clears the running hash to zero and empties the result
// register.
`default_nettype none
module word_mix_hash64 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [31:0] total_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest
);
    import wmh64_pkg::*;

    // Sequencer and datapath registers.
    phase_t      phase_reg, phase_next;
    mul_step_t   step_reg, step_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] operand_reg, operand_next;
    logic        last_reg, last_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] mul_reg, mul_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] digest_reg, digest_next;

    // Combinational helpers.
    logic        accept;
    logic        emit_ok;
    logic        mul_done;
    logic [63:0] seed;
    logic [63:0] masked_word;
    logic [63:0] coef;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] full_prod;
    logic [63:0] mix_xor;
    logic [63:0] mix_rot;
    logic [63:0] mix_sum;

    assign in_stall  = (phase_reg != PH_IDLE);
    assign accept    = in_valid && (phase_reg == PH_IDLE);
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;
    assign emit_ok   = !out_valid_reg || !out_stall;
    assign mul_done  = (step_reg == MS_SUM);

    // Seed and masked word of an incoming request.
    assign seed        = first_word ? (HASH_K1 ^ {32'd0, total_length}) : acc_reg;
    assign masked_word = data_word & lane_mask(valid_bytes);

    // The first multiply of both the mix and the finalizer uses K1, the second K2.
    always_comb
    begin
        case (phase_reg)
            PH_MIX1, PH_FIN1: coef = HASH_K1;
            default:          coef = HASH_K2;
        endcase
    end

    // Operand halves fed to the shared multiplier at each step.
    always_comb
    begin
        case (step_reg)
            MS_LOLO:
            begin
                mul_a = operand_reg[31:0];
                mul_b = coef[31:0];
            end
            MS_HILO:
            begin
                mul_a = operand_reg[63:32];
                mul_b = coef[31:0];
            end
            MS_LOHI:
            begin
                mul_a = operand_reg[31:0];
                mul_b = coef[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Low 64 bits of the product once the last cross term is in.
    assign full_prod = {prod_reg[63:32] + mul_reg[31:0], prod_reg[31:0]};
    assign mix_xor   = acc_reg ^ full_prod;
    assign mix_rot   = {mix_xor[63-MIX_ROT:0], mix_xor[63:64-MIX_ROT]};
    assign mix_sum   = full_prod + HASH_K3;

    // Next phase of the sequencer.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (accept) begin
                    if (valid_bytes != 4'd0) begin
                        phase_next = PH_MIX1;
                    end else if (last_word) begin
                        phase_next = PH_FIN1;
                    end
                end
            end
            PH_MIX1:
            begin
                if (mul_done) begin
                    phase_next = PH_MIX2;
                end
            end
            PH_MIX2:
            begin
                if (mul_done) begin
                    phase_next = last_reg ? PH_FIN1 : PH_IDLE;
                end
            end
            PH_FIN1:
            begin
                if (mul_done) begin
                    phase_next = PH_FIN2;
                end
            end
            PH_FIN2:
            begin
                if (mul_done) begin
                    phase_next = PH_EMIT;
                end
            end
            PH_EMIT:
            begin
                if (emit_ok) begin
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // Datapath and output values for each phase.
    always_comb
    begin
        step_next      = step_reg;
        acc_next       = acc_reg;
        operand_next   = operand_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg && out_stall;
        digest_next    = digest_reg;

        // Multiply steps: issue three partial products, then accumulate.
        if (phase_reg == PH_MIX1 || phase_reg == PH_MIX2
            || phase_reg == PH_FIN1 || phase_reg == PH_FIN2) begin
            mul_next = mul_a * mul_b;
            case (step_reg)
                MS_LOLO: step_next = MS_HILO;
                MS_HILO:
                begin
                    prod_next = mul_reg;
                    step_next = MS_LOHI;
                end
                MS_LOHI:
                begin
                    prod_next = {prod_reg[63:32] + mul_reg[31:0], prod_reg[31:0]};
                    step_next = MS_SUM;
                end
                default: step_next = MS_LOLO;
            endcase
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept) begin
                    acc_next  = seed;
                    last_next = last_word;
                    if (valid_bytes != 4'd0) begin
                        operand_next = masked_word;
                    end else begin
                        operand_next = seed ^ (seed >> FIN_SH1);
                    end
                    step_next = MS_LOLO;
                end
            end
            PH_MIX1:
            begin
                // Xor the word product in and rotate; this is the next multiplicand.
                if (mul_done) begin
                    acc_next     = mix_rot;
                    operand_next = mix_rot;
                end
            end
            PH_MIX2:
            begin
                if (mul_done) begin
                    acc_next     = mix_sum;
                    operand_next = mix_sum ^ (mix_sum >> FIN_SH1);
                end
            end
            PH_FIN1:
            begin
                if (mul_done) begin
                    operand_next = full_prod ^ (full_prod >> FIN_SH2);
                end
            end
            PH_FIN2:
            begin
                if (mul_done) begin
                    operand_next = full_prod ^ (full_prod >> FIN_SH3);
                end
            end
            PH_EMIT:
            begin
                // Load the result register once it is free.
                if (emit_ok) begin
                    digest_next    = operand_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                step_next = MS_LOLO;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            step_reg      <= MS_LOLO;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        operand_reg <= operand_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        mul_reg     <= mul_next;
        digest_reg  <= digest_next;
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the word_mix_hash64 streaming hash block.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wmh64_pkg::HASH_K1;
    import wmh64_pkg::HASH_K2;
    import wmh64_pkg::HASH_K3;
    import wmh64_pkg::MIX_ROT;
    import wmh64_pkg::FIN_SH1;
    import wmh64_pkg::FIN_SH2;
    import wmh64_pkg::FIN_SH3;

    localparam int unsigned NUM_DIRECTED = 23;
    localparam int unsigned PHASE_REQUESTS = 309;

    // One directed request; has_fixed marks a row whose digest is typed in.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        is_first;
        logic        is_last;
        logic [31:0] length;
        logic        has_fixed;
        logic [63:0] fixed_digest;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] data_word = '0;
    logic [3:0]  valid_bytes = '0;
    logic        first_word = 1'b0;
    logic        last_word = 1'b0;
    logic [31:0] total_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest;

    // Running copy of the block state used for prediction.
    logic [63:0] running_hash = '0;

    logic [63:0] expected_digests[$];
    logic [63:0] oldest_digest;
    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;

    // Directed rows: extremes, empty messages, saturating counts, repeated
    // starts, requests without a start and a zero-byte last word.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // No start after reset, nothing mixed: the finalized zero hash is zero.
        '{64'h0123456789abcdef, 4'd0, 1'b0, 1'b1, 32'd0, 1'b1, 64'd0},
        '{64'hffffffffffffffff, 4'd8, 1'b0, 1'b0, 32'hffffffff, 1'b0, 64'd0},
        '{64'hfedcba9876543210, 4'd3, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h0000000000000000, 4'd0, 1'b1, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'hffffffffffffffff, 4'd8, 1'b1, 1'b1, 32'hffffffff, 1'b0, 64'd0},
        '{64'h0000000000000000, 4'd8, 1'b1, 1'b0, 32'd21, 1'b0, 64'd0},
        '{64'h0123456789abcdef, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'h8000000000000001, 4'd5, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h5555555555555555, 4'd15, 1'b1, 1'b1, 32'd8, 1'b0, 64'd0},
        '{64'haaaaaaaaaaaaaaaa, 4'd9, 1'b1, 1'b1, 32'd8, 1'b0, 64'd0},
        '{64'hdeadbeefcafef00d, 4'd3, 1'b1, 1'b0, 32'd19, 1'b0, 64'd0},
        '{64'h0f0f0f0f0f0f0f0f, 4'd8, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'hf0f0f0f0f0f0f0f0, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h1111111111111111, 4'd8, 1'b1, 1'b0, 32'd16, 1'b0, 64'd0},
        '{64'h2222222222222222, 4'd8, 1'b1, 1'b0, 32'd10, 1'b0, 64'd0},
        '{64'h3333333333333333, 4'd2, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h4444444444444444, 4'd8, 1'b1, 1'b0, 32'd8, 1'b0, 64'd0},
        '{64'h7777777777777777, 4'd0, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h0000000100000002, 4'd8, 1'b1, 1'b0, 32'd1000, 1'b0, 64'd0},
        '{64'h9999999999999999, 4'd8, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'hcccccccccccccccc, 4'd4, 1'b0, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'hffffffffffffffff, 4'd7, 1'b1, 1'b1, 32'd0, 1'b0, 64'd0},
        '{64'h0000000000000001, 4'd1, 1'b1, 1'b1, 32'd1, 1'b0, 64'd0}
    };

    word_mix_hash64 u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .first_word   (first_word),
        .last_word    (last_word),
        .total_length (total_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest       (digest)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the running hash by one request; returns 1 when a digest follows.
    function automatic logic hash_step(input logic [63:0] w, input logic [3:0] nbytes,
                                       input logic is_first, input logic is_last,
                                       input logic [31:0] length,
                                       output logic [63:0] result);
        logic [63:0] keep;
        logic [63:0] x;
        int unsigned lanes;
        lanes = (nbytes > 4'd8) ? 8 : int'(nbytes);
        keep = (lanes == 8) ? '1 : ((64'd1 << (8 * lanes)) - 64'd1);
        if (is_first)
        begin
            running_hash = HASH_K1 ^ {32'd0, length};
        end
        // Lanes at and above the byte count are cleared before mixing.
        if (lanes != 0)
        begin
            x = running_hash ^ ((w & keep) * HASH_K1);
            x = (x << MIX_ROT) | (x >> (64 - MIX_ROT));
            running_hash = x * HASH_K2 + HASH_K3;
        end
        result = '0;
        // Avalanche the hash on the last word; the running hash itself is kept.
        if (is_last)
        begin
            x = running_hash;
            x = x ^ (x >> FIN_SH1);
            x = x * HASH_K1;
            x = x ^ (x >> FIN_SH2);
            x = x * HASH_K2;
            x = x ^ (x >> FIN_SH3);
            result = x;
        end
        return is_last;
    endfunction

    // Offer one request after random idle cycles and wait until it is taken.
    task automatic send_request(input logic [63:0] w, input logic [3:0] nbytes,
                                input logic is_first, input logic is_last,
                                input logic [31:0] length, input logic has_fixed,
                                input logic [63:0] fixed_digest);
        logic [63:0] predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_word <= w;
        valid_bytes <= nbytes;
        first_word <= is_first;
        last_word <= is_last;
        total_length <= length;
        if (hash_step(w, nbytes, is_first, is_last, length, predicted))
        begin
            expected_digests.push_back(has_fixed ? fixed_digest : predicted);
        end
        requests_sent++;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Well-formed message with random content; a few are short mid-message
    // or lose their last word.
    task automatic send_message();
        int unsigned n_words;
        int unsigned tail_bytes;
        logic [31:0] length;
        logic        drop_last;
        logic [3:0]  nbytes;
        logic        is_last;
        n_words = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        tail_bytes = $urandom_range(8);
        length = ($urandom_range(9) == 0) ? $urandom : 32'(8 * (n_words - 1) + tail_bytes);
        drop_last = ($urandom_range(19) == 0);
        for (int i = 0; i < n_words; i++)
        begin
            is_last = (i == n_words - 1) && !drop_last;
            if (i == n_words - 1)
            begin
                nbytes = 4'(tail_bytes);
            end
            else if ($urandom_range(9) == 0)
            begin
                nbytes = 4'($urandom_range(15));
            end
            else
            begin
                nbytes = 4'd8;
            end
            send_request({$urandom, $urandom}, nbytes, i == 0, is_last, length, 1'b0, '0);
        end
    endtask

    // Hold the sender off until every expected digest has been seen.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_digests.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: check each accepted digest against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("digest: none expected, actual %h", digest);
                    mismatch_count++;
                end
                else
                begin
                    oldest_digest = expected_digests.pop_front();
                    if (digest !== oldest_digest)
                    begin
                        $error("digest: expected %h, actual %h", oldest_digest, digest);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Main sequence: reset, directed rows, then three random phases.
    initial
    begin
        int unsigned target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 27;
        receiver_idle_pct = 49;
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].word, directed_rows[i].nbytes,
                         directed_rows[i].is_first, directed_rows[i].is_last,
                         directed_rows[i].length, directed_rows[i].has_fixed,
                         directed_rows[i].fixed_digest);
        end
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 27;
                    receiver_idle_pct = 49;
                end
                1:
                begin
                    sender_idle_pct = 49;
                    receiver_idle_pct = 27;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target)
            begin
                // Mostly whole messages, the rest are requests with random fields.
                if ($urandom_range(4) == 0)
                begin
                    send_request({$urandom, $urandom}, 4'($urandom_range(15)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom, 1'b0, '0);
                end
                else
                begin
                    send_message();
                end
            end
            wait_for_drain();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
